// ===== sv/sor_linear_solver_macros.svh =====
`ifndef SOR_LINEAR_SOLVER_MACROS_SVH
`define SOR_LINEAR_SOLVER_MACROS_SVH
// concurrent assertion helpers
`define SOR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SOR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/sor_pkg.sv =====
package sor_pkg;
  localparam int unsigned MaxN = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned WeightFrac = 14;
  localparam int unsigned IdxW = 5;
  localparam int unsigned AddrW = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [1:0] FuncMatrix = 2'd0;
  localparam logic [1:0] FuncRhs = 2'd1;
  localparam logic [1:0] FuncStart = 2'd2;
  localparam logic [1:0] FuncSolve = 2'd3;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusParam = 2'd1;
  localparam logic [1:0] StatusDiag = 2'd2;

  localparam logic [CfgIdxW-1:0] RegSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIter = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWeight = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] row;
    logic [4:0] col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [4:0] index;
    logic signed [31:0] solution_value;
    logic [1:0] status;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic signed [63:0] dividend;
    logic signed [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [63:0] quotient;
  } div_rsp_t;
endpackage

// ===== sv/sor_if.sv =====
interface sor_in_if;
  import sor_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sor_out_if;
  import sor_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sor_divider.sv =====
module sor_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sor_pkg::div_req_t   req_i,
  output sor_pkg::div_rsp_t   rsp_o
);
  import sor_pkg::*;

  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic neg_q, neg_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [64:0] trial;
  logic [63:0] ua;

  always_comb begin
    ua = req_i.dividend[63] ? 64'(-req_i.dividend) : 64'(req_i.dividend);
    trial = {rem_q, quo_q[63]} - {33'd0, dvs_q};
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = ua;
      dvs_d = req_i.divisor[31] ? 32'(-req_i.divisor) : 32'(req_i.divisor);
      neg_d = req_i.dividend[63] ^ req_i.divisor[31];
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[64]) begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end else begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quotient = neg_q ? 64'(-quo_q) : quo_q;
endmodule

// ===== sv/sor_linear_solver.sv =====
// successive over-relaxation solver, signed q16.16 data
// in_if: load or solve transactions (func, row, col, value)
//   matrix, rhs and start writes produce nothing
//   a solve transaction runs the configured sweeps, then streams x entries
// out_if: index, solution_value, status, last; last marks the final entry
// a bad parameter set or a zero diagonal gives a single transaction instead
// cfg port: cfg_we_i, cfg_idx_i (0 size, 1 iterations, 2 weight), cfg_data_i
// a solve checks every diagonal entry, then per row of each sweep runs
//   a multiply-accumulate over the row and a division in the shared
//   radix-2 divider; the serial multiply-accumulate and the bit-serial
//   divider set how long a solve runs
// the block takes no transaction while a solve runs or results are pending
// a stalled receiver holds the output register; the block waits with it
// reset clears control state and x to zero; matrix and rhs stay undefined
module sor_linear_solver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sor_in_if.sink                       in_if,
  sor_out_if.source                    out_if,
  input  logic                         cfg_we_i,
  input  logic [sor_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sor_pkg::CfgDataW-1:0] cfg_data_i
);
  import sor_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIAG  = 10'b0000000010,
    S_ACC   = 10'b0000000100,
    S_DRAIN = 10'b0000001000,
    S_DIVS  = 10'b0000010000,
    S_DIVW  = 10'b0000100000,
    S_WMUL  = 10'b0001000000,
    S_UPD   = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] size_q;
  logic [15:0] iter_q;
  logic [15:0] weight_q;

  logic signed [31:0] mat_mem [MaxN*MaxN];
  logic signed [31:0] rhs_mem [MaxN];
  logic signed [31:0] x_mem [MaxN];
  logic [MaxN-1:0] x_vld_q;

  logic signed [31:0] mat_rd_q, x_rd_q, rhs_rd_q, diag_q;
  logic [AddrW-1:0] mat_ra;
  logic [IdxW-1:0] x_ra;
  logic x_rd_vld_q;

  logic [5:0] n;
  logic [IdxW-1:0] r_q, c_q;
  logic [15:0] it_q;
  logic [1:0] pipe_q;
  logic signed [63:0] prod_q, acc_q, q_q;
  logic signed [63:0] wp_q;
  logic signed [31:0] xr_q;
  div_req_t div_req;
  div_rsp_t div_rsp;
  out_item_t out_q;
  logic out_vld_q;
  logic in_fire;
  logic x_we;
  logic [IdxW-1:0] x_wa;
  logic signed [31:0] x_wd;
  logic signed [63:0] xsum;
  logic signed [64:0] accsub;
  logic signed [63:0] qc;
  logic param_bad;
  logic signed [31:0] x_val;

  assign n = (size_q > 6'(MaxN)) ? 6'(MaxN) : size_q;
  assign param_bad = (iter_q == '0) || (weight_q == '0) ||
                     (weight_q >= 16'(2 << WeightFrac)) || (n == '0);
  assign in_if.ready = (state_q == S_IDLE) && !out_vld_q;
  assign in_fire = in_if.valid && in_if.ready;
  assign x_val = x_rd_vld_q ? x_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 6'd1;
      iter_q <= 16'd1;
      weight_q <= 16'd16384;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSize: size_q <= cfg_data_i[5:0];
        RegIter: iter_q <= cfg_data_i;
        RegWeight: weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sor_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    mat_ra = {r_q, c_q};
    x_ra = c_q;
    if (state_q == S_DIAG || state_q == S_DRAIN) begin
      mat_ra = {r_q, r_q};
    end else if (state_q == S_UPD || state_q == S_WMUL || state_q == S_DIVW ||
                 state_q == S_DIVS) begin
      x_ra = r_q;
    end else if (state_q == S_EMIT || state_q == S_WAIT) begin
      x_ra = r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_if.data.func == FuncMatrix) begin
      mat_mem[{in_if.data.row, in_if.data.col}] <= in_if.data.value;
    end
    if (in_fire && in_if.data.func == FuncRhs) begin
      rhs_mem[in_if.data.row] <= in_if.data.value;
    end
    if (x_we) begin
      x_mem[x_wa] <= x_wd;
    end
    mat_rd_q <= mat_mem[mat_ra];
    x_rd_q <= x_mem[x_ra];
    rhs_rd_q <= rhs_mem[r_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q <= '0;
      x_rd_vld_q <= 1'b0;
    end else begin
      x_rd_vld_q <= x_vld_q[x_ra];
      if (x_we) begin
        x_vld_q[x_wa] <= 1'b1;
      end
    end
  end

  always_comb begin
    x_we = 1'b0;
    x_wa = r_q;
    x_wd = '0;
    xsum = 64'(xr_q) + (wp_q >>> WeightFrac);
    if (in_fire && in_if.data.func == FuncStart) begin
      x_we = 1'b1;
      x_wa = in_if.data.row;
      x_wd = in_if.data.value;
    end else if (state_q == S_UPD) begin
      x_we = 1'b1;
      if (xsum > 64'sd2147483647) begin
        x_wd = 32'sh7fffffff;
      end else if (xsum < -64'sd2147483648) begin
        x_wd = 32'sh80000000;
      end else begin
        x_wd = xsum[31:0];
      end
    end
  end

  always_comb begin
    accsub = 65'(acc_q) - 65'(prod_q);
    qc = div_rsp.quotient;
    if (qc > 64'sh0000800000000000) begin
      qc = 64'sh0000800000000000;
    end else if (qc < -64'sh0000800000000000) begin
      qc = -64'sh0000800000000000;
    end
  end

  assign div_req.start = (state_q == S_DIVS);
  assign div_req.dividend = acc_q;
  assign div_req.divisor = diag_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && in_if.data.func == FuncSolve && !param_bad) begin
          state_d = S_DIAG;
        end
      end
      S_DIAG: begin
        if (pipe_q == 2'd2 && mat_rd_q == '0) begin
          state_d = S_IDLE;
        end else if (pipe_q == 2'd2 && 6'(r_q) == n - 6'd1) begin
          state_d = S_ACC;
        end
      end
      S_ACC: if (6'(c_q) == n - 6'd1) state_d = S_DRAIN;
      S_DRAIN: if (pipe_q == 2'd3) state_d = S_DIVS;
      S_DIVS: state_d = S_DIVW;
      S_DIVW: if (div_rsp.done) state_d = S_WMUL;
      S_WMUL: state_d = S_UPD;
      S_UPD: begin
        if (6'(r_q) == n - 6'd1 && it_q == iter_q - 16'd1) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_ACC;
        end
      end
      S_EMIT: if (pipe_q == 2'd2) state_d = S_WAIT;
      S_WAIT: begin
        if (out_vld_q && out_if.ready) begin
          state_d = (6'(r_q) == n - 6'd1) ? S_IDLE : S_EMIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q <= '0;
      c_q <= '0;
      it_q <= '0;
      pipe_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_vld_q && out_if.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          r_q <= '0;
          c_q <= '0;
          it_q <= '0;
          pipe_q <= '0;
          if (in_fire && in_if.data.func == FuncSolve && param_bad) begin
            out_vld_q <= 1'b1;
          end
        end
        S_DIAG: begin
          if (pipe_q != 2'd2) begin
            pipe_q <= pipe_q + 2'd1;
          end else if (mat_rd_q == '0) begin
            out_vld_q <= 1'b1;
          end else if (6'(r_q) == n - 6'd1) begin
            r_q <= '0;
            pipe_q <= '0;
          end else begin
            r_q <= r_q + 5'd1;
            pipe_q <= '0;
          end
        end
        S_ACC: begin
          pipe_q <= '0;
          if (6'(c_q) != n - 6'd1) c_q <= c_q + 5'd1;
        end
        S_DRAIN: pipe_q <= pipe_q + 2'd1;
        S_UPD: begin
          c_q <= '0;
          if (6'(r_q) == n - 6'd1) begin
            r_q <= '0;
            it_q <= it_q + 16'd1;
          end else begin
            r_q <= r_q + 5'd1;
          end
          pipe_q <= '0;
        end
        S_EMIT: begin
          pipe_q <= pipe_q + 2'd1;
          if (pipe_q == 2'd2) out_vld_q <= 1'b1;
        end
        S_WAIT: begin
          pipe_q <= '0;
          if (out_vld_q && out_if.ready && 6'(r_q) != n - 6'd1) r_q <= r_q + 5'd1;
        end
        default: ;
      endcase
    end
  end

  // two-deep read pipeline: address, ram read, then product
  logic acc_act_q, acc_act2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_act_q <= 1'b0;
      acc_act2_q <= 1'b0;
    end else begin
      acc_act_q <= (state_q == S_ACC);
      acc_act2_q <= acc_act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mat_rd_q) * 64'(x_val);
    if (state_q == S_DRAIN && pipe_q == 2'd3) begin
      diag_q <= mat_rd_q;
    end
    if (acc_act_q && !acc_act2_q) begin
      acc_q <= 64'(rhs_rd_q) <<< FracBits;
    end else if (acc_act2_q) begin
      if (accsub > 65'sh0_7fffffffffffffff) begin
        acc_q <= 64'sh7fffffffffffffff;
      end else if (accsub < -65'sh0_7fffffffffffffff) begin
        acc_q <= -64'sh7fffffffffffffff;
      end else begin
        acc_q <= accsub[63:0];
      end
    end
    if (div_rsp.done) begin
      q_q <= qc;
    end
    wp_q <= q_q * 64'($signed({1'b0, weight_q}));
    if (state_q == S_WMUL) begin
      xr_q <= x_val;
    end
    if (state_q == S_IDLE && !out_vld_q) begin
      out_q.index <= '0;
      out_q.solution_value <= '0;
      out_q.status <= StatusParam;
      out_q.last <= 1'b1;
    end else if (state_q == S_DIAG) begin
      out_q.status <= StatusDiag;
    end else if (state_q == S_EMIT && pipe_q == 2'd2) begin
      out_q.index <= r_q;
      out_q.solution_value <= x_val;
      out_q.status <= StatusOk;
      out_q.last <= (6'(r_q) == n - 6'd1);
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data = out_q;
endmodule

// ===== sv/sor_checker.sv =====
`include "sor_linear_solver_macros.svh"
module sor_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [1:0] out_status
);
  import sor_pkg::*;
  `SOR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `SOR_ASSERT_IMP(a_err_last, clk_i, rst_ni, out_valid && out_status != StatusOk, out_last)
  `SOR_ASSERT_IMP(a_no_take_out, clk_i, rst_ni, out_valid, !in_ready)
endmodule

bind sor_linear_solver sor_checker u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_last  (out_if.data.last),
  .out_status(out_if.data.status)
);

// ===== tb/sv/tb_sor_linear_solver.sv =====
`timescale 1ns / 100ps

module tb_sor_linear_solver;
  import sor_pkg::*;

  typedef struct {
    bit is_cfg;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgDataW-1:0] reg_data;
    in_item_t item;
    bit typed;
    out_item_t want;
  } step_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sor_in_if in_if ();
  sor_out_if out_if ();

  sor_linear_solver i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if.sink),
    .out_if     (out_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic signed [31:0] coef_mem [MaxN*MaxN];
  logic signed [31:0] rhs_mem [MaxN];
  logic signed [31:0] x_mem [MaxN];
  logic [5:0] cfg_size;
  logic [15:0] cfg_sweeps;
  logic [15:0] cfg_weight;

  out_item_t solution_q [$];
  step_t steps [$];

  int errors = 0;
  int sent = 0;
  int solves = 0;
  int results_seen = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int rdy_mode = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int rdy_cyc = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic out_item_t mk_out(logic [4:0] idx, logic signed [31:0] v,
                                       logic [1:0] st, logic lst);
    out_item_t o;
    o.index = idx;
    o.solution_value = v;
    o.status = st;
    o.last = lst;
    return o;
  endfunction

  // computes the results of one transaction and updates the predictor state
  function automatic void predict_transaction(in_item_t t, ref out_item_t res [$]);
    int n;
    bit zero_diag;
    longint acc, p, q, delta, s, maxv;
    logic signed [64:0] d;
    res.delete();
    maxv = 64'sh7fff_ffff_ffff_ffff;
    case (t.func)
      FuncMatrix: coef_mem[{t.row, t.col}] = t.value;
      FuncRhs: rhs_mem[t.row] = t.value;
      FuncStart: x_mem[t.row] = t.value;
      default: begin
        n = (cfg_size > MaxN) ? MaxN : cfg_size;
        zero_diag = 1'b0;
        if (cfg_sweeps == 0 || cfg_weight == 0 || cfg_weight >= 16'd32768 || n == 0) begin
          res.push_back(mk_out(0, 0, StatusParam, 1'b1));
          return;
        end
        for (int r = 0; r < n; r++)
          if (coef_mem[r*MaxN+r] == 0) zero_diag = 1'b1;
        if (zero_diag) begin
          res.push_back(mk_out(0, 0, StatusDiag, 1'b1));
          return;
        end
        for (int it = 0; it < cfg_sweeps; it++) begin
          for (int r = 0; r < n; r++) begin
            acc = longint'(rhs_mem[r]) * 65536;
            for (int c = 0; c < n; c++) begin
              p = longint'(coef_mem[r*MaxN+c]) * longint'(x_mem[c]);
              d = 65'(acc) - 65'(p);
              if (d > 65'(maxv)) acc = maxv;
              else if (d < -65'(maxv)) acc = -maxv;
              else acc = d[63:0];
            end
            q = acc / longint'(coef_mem[r*MaxN+r]);
            if (q > (64'sd1 <<< 47)) q = 64'sd1 <<< 47;
            if (q < -(64'sd1 <<< 47)) q = -(64'sd1 <<< 47);
            delta = (q * longint'({48'd0, cfg_weight})) >>> WeightFrac;
            s = longint'(x_mem[r]) + delta;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            x_mem[r] = s[31:0];
          end
        end
        for (int r = 0; r < n; r++)
          res.push_back(mk_out(r[4:0], x_mem[r], StatusOk, r == n - 1));
      end
    endcase
  endfunction

  function automatic in_item_t mk_in(logic [1:0] f, logic [4:0] r, logic [4:0] c,
                                     logic [31:0] v);
    in_item_t t;
    t.func = f;
    t.row = r;
    t.col = c;
    t.value = v;
    return t;
  endfunction

  function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    step_t s;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_data = v;
    s.typed = 1'b0;
    steps.push_back(s);
  endfunction

  function automatic void add_item(in_item_t t, bit typed = 1'b0,
                                   out_item_t want = '0);
    step_t s;
    s.is_cfg = 1'b0;
    s.item = t;
    s.typed = typed;
    s.want = want;
    steps.push_back(s);
  endfunction

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = v;
    case (idx)
      RegSize: cfg_size = v[5:0];
      RegIter: cfg_sweeps = v;
      RegWeight: cfg_weight = v;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // offers one transaction, waits for it to be taken, then queues its results
  task automatic send_item(in_item_t t, bit typed, out_item_t want);
    out_item_t res [$];
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_if.valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_if.valid = 1'b1;
    in_if.data = t;
    do @(posedge clk_i); while (!in_if.ready);
    predict_transaction(t, res);
    if (t.func == FuncSolve) solves++;
    if (typed) solution_q.push_back(want);
    else foreach (res[i]) solution_q.push_back(res[i]);
    sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    burst_left = 0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed({1'b0, 19'($urandom)}) - 32'sd262144);
    endcase
  endfunction

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk_i) begin
    rdy_cyc++;
    if (hold_req) begin
      if (hold_cnt == 0) hold_cnt = 400;
      out_if.ready = 1'b0;
      hold_cnt--;
      if (hold_cnt == 0) hold_req = 1'b0;
    end else begin
      case (rdy_mode)
        0: out_if.ready = 1'b1;
        1: out_if.ready = 1'($urandom_range(0, 1));
        default: out_if.ready = (rdy_cyc % 7) < 3;
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (solution_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = solution_q.pop_front();
        if (out_if.data.index !== e.index) begin
          $error("index: expected %0d, actual %0d", e.index, out_if.data.index);
          errors++;
        end
        if (out_if.data.solution_value !== e.solution_value) begin
          $error("solution_value: expected %h, actual %h", e.solution_value,
                 out_if.data.solution_value);
          errors++;
        end
        if (out_if.data.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_if.data.status);
          errors++;
        end
        if (out_if.data.last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_if.data.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("sor_linear_solver test failed");
    $finish;
  end

  initial begin
    int n;
    int phase;
    in_item_t t;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cfg_size = 6'd1;
    cfg_sweeps = 16'd1;
    cfg_weight = 16'd16384;
    foreach (x_mem[i]) x_mem[i] = '0;
    foreach (rhs_mem[i]) rhs_mem[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;

    // directed table
    add_item(mk_in(FuncMatrix, 0, 0, 32'h0001_0000));
    add_item(mk_in(FuncRhs, 0, 0, 32'h0003_0000));
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 32'h0003_0000, StatusOk, 1));
    add_item(mk_in(FuncMatrix, 0, 0, 32'h0000_0001));
    add_item(mk_in(FuncRhs, 0, 0, 32'h7fff_ffff));
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 32'h7fff_ffff, StatusOk, 1));
    add_item(mk_in(FuncRhs, 0, 0, 32'h8000_0000));
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 32'h8000_0000, StatusOk, 1));
    add_item(mk_in(FuncStart, 0, 0, 32'h0000_0000));
    add_cfg(RegWeight, 16'd0);
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 0, StatusParam, 1));
    add_cfg(RegWeight, 16'd32768);
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 0, StatusParam, 1));
    add_cfg(RegWeight, 16'd32767);
    add_cfg(RegIter, 16'd0);
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 0, StatusParam, 1));
    add_cfg(RegWeight, 16'hffff);
    add_cfg(RegIter, 16'hffff);
    add_cfg(RegSize, 16'd0);
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 0, StatusParam, 1));
    add_cfg(RegWeight, 16'd16384);
    add_cfg(RegIter, 16'd1);
    add_cfg(RegSize, 16'd32);
    add_item(mk_in(FuncMatrix, 0, 0, 32'h0000_0000));
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 0, StatusDiag, 1));
    add_cfg(RegSize, 16'd63);
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 0, StatusDiag, 1));
    add_item(mk_in(FuncMatrix, 31, 31, 32'h7fff_ffff));
    add_item(mk_in(FuncMatrix, 31, 0, 32'h8000_0000));
    add_item(mk_in(FuncRhs, 31, 0, 32'h8000_0000));
    add_item(mk_in(FuncStart, 31, 0, 32'h7fff_ffff));
    add_cfg(RegSize, 16'd2);
    add_item(mk_in(FuncMatrix, 0, 0, 32'h0002_0000));
    add_item(mk_in(FuncMatrix, 0, 1, 32'hffff_0000));
    add_item(mk_in(FuncMatrix, 1, 0, 32'h0001_0000));
    add_item(mk_in(FuncMatrix, 1, 1, 32'h0000_0000));
    add_item(mk_in(FuncRhs, 1, 0, 32'h0002_8000));
    add_item(mk_in(FuncSolve, 0, 0, 0), 1, mk_out(0, 0, StatusDiag, 1));
    add_item(mk_in(FuncMatrix, 1, 1, 32'h0003_0000));
    add_item(mk_in(FuncSolve, 0, 0, 0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        drain();
        cfg_write(steps[i].reg_idx, steps[i].reg_data);
      end else begin
        send_item(steps[i].item, steps[i].typed, steps[i].want);
      end
    end

    // random systems: full load, up to three random writes as noise, then solves
    phase = 0;
    while (sent < 300) begin
      drain();
      gaps_on = (phase % 4) != 1;
      rdy_mode = $urandom_range(0, 2);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      cfg_write(RegSize, 16'(n));
      cfg_write(RegIter, 16'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3)));
      cfg_write(RegWeight, 16'($urandom_range(0, 9) == 0 ? $urandom_range(32768, 65535)
                                                      : $urandom_range(1, 32767)));
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) begin
          if (r == c) begin
            if ($urandom_range(0, 19) == 0)
              t = mk_in(FuncMatrix, r, c, 0);
            else
              t = mk_in(FuncMatrix, r, c, ($urandom_range(0, 1) ? 1 : -1) *
                        (n * 32'h0004_0000 + $urandom_range(0, 32'h0004_0000)));
          end else begin
            t = mk_in(FuncMatrix, r, c, rand_val());
          end
          send_item(t, 0, '0);
        end
        send_item(mk_in(FuncRhs, r, $urandom, rand_val()), 0, '0);
      end
      repeat ($urandom_range(0, 3))
        send_item(mk_in($urandom_range(0, 2), $urandom, $urandom, $urandom), 0, '0);
      if (phase == 2) hold_req = 1'b1;
      send_item(mk_in(FuncSolve, $urandom, $urandom, $urandom), 0, '0);
      if (phase == 2 || $urandom_range(0, 3) == 0)
        send_item(mk_in(FuncSolve, $urandom, $urandom, $urandom), 0, '0);
      if (phase == 2)
        repeat (4) send_item(mk_in(FuncStart, $urandom, 0, rand_val()), 0, '0);
      phase++;
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d input transactions, %0d solves, %0d result transactions",
             sent, solves, results_seen);
    $display("random phases: %0d, register extremes and error statuses included", phase);
    if (errors == 0 && solution_q.size() == 0)
      $display("sor_linear_solver test passed");
    else
      $display("sor_linear_solver test failed");
    $finish;
  end

endmodule
